### hw/rtl/efr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efr_pkg: shared types and constants of the escaped frame receiver
// Framing byte codes, buffer limits and the result item layout.
// ----------------------------------------------------------------------------
package efr_pkg;

    localparam int RawBufferBytes = 128;
    localparam int RawCountWidth  = $clog2(RawBufferBytes + 1);
    localparam int LenWidth       = 7;

    localparam logic [7:0] StartByte = 8'h61;
    localparam logic [7:0] StartCode = 8'h62;
    localparam logic [7:0] EndByte   = 8'h63;
    localparam logic [7:0] EndCode   = 8'h64;
    localparam logic [7:0] EscByte   = 8'h70;
    localparam logic [7:0] EscCode   = 8'h71;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_RESTART  = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                 kind;
        logic [7:0]            data_byte;
        logic                  bad_escape;
        logic [LenWidth-1:0]   frame_length;
    } t_result;

endpackage
`default_nettype wire

### hw/rtl/efr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efr_if: channel interfaces of the escaped frame receiver
// Raw byte channel and decoded result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface efr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efr_out_if;
    logic                          valid;
    logic                          ready;
    efr_pkg::t_kind                kind;
    logic [7:0]                    data_byte;
    logic                          bad_escape;
    logic [efr_pkg::LenWidth-1:0]  frame_length;

    modport source (output valid, output kind, output data_byte, output bad_escape,
                    output frame_length, input ready);
    modport sink   (input valid, input kind, input data_byte, input bad_escape,
                    input frame_length, output ready);
endinterface
`default_nettype wire

### hw/rtl/efr_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efr_in_stage: input register
// Captures one raw byte per beat and holds it until the decoder takes it.
// ----------------------------------------------------------------------------
module efr_in_stage (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    efr_in_if.sink     i_rx,
    input  wire logic  i_dn_ready,
    output logic       o_dn_valid,
    output logic [7:0] o_dn_byte
);
    import efr_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;
    logic       accept;

    // A new beat may enter when the register is empty or the held one leaves in the same cycle.
    assign i_rx.ready = !r_valid || i_dn_ready;
    assign accept     = i_rx.valid && i_rx.ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_dn_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_dn_valid = r_valid;
    assign o_dn_byte  = r_byte;

endmodule
`default_nettype wire

### hw/rtl/efr_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efr_decode: frame state and byte decoder
// Tracks the frame mode and counters and forms at most one result per byte.
// ----------------------------------------------------------------------------
module efr_decode (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_res_ready,
    output logic             o_ready,
    output logic             o_res_valid,
    output efr_pkg::t_result o_res
);
    import efr_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_FRAME  = 2'd1,
        MODE_ESCAPE = 2'd2
    } t_mode;

    t_mode                    r_mode;
    t_mode                    n_mode;
    logic [RawCountWidth-1:0] r_raw;
    logic [RawCountWidth-1:0] n_raw;
    logic [LenWidth-1:0]      r_dec;
    logic [LenWidth-1:0]      n_dec;
    logic                     emit;
    t_result                  res;
    logic                     advance;

    assign o_ready     = i_res_ready;
    assign advance     = i_valid && i_res_ready;
    assign o_res_valid = i_valid && emit;
    assign o_res       = res;

    always_comb begin
        n_mode = r_mode;
        n_raw  = r_raw;
        n_dec  = r_dec;
        emit   = 1'b0;
        res    = '0;
        res.kind = KIND_PAYLOAD;
        case (r_mode)
            MODE_FRAME, MODE_ESCAPE: begin
                if (i_byte == StartByte) begin
                    // A start byte inside a frame drops it and opens a new one.
                    n_mode   = MODE_FRAME;
                    n_raw    = RawCountWidth'(1);
                    n_dec    = '0;
                    emit     = 1'b1;
                    res.kind = KIND_RESTART;
                end else if (r_raw >= RawCountWidth'(RawBufferBytes)) begin
                    n_mode   = MODE_IDLE;
                    n_raw    = '0;
                    n_dec    = '0;
                    emit     = 1'b1;
                    res.kind = KIND_OVERFLOW;
                end else if (i_byte == EndByte) begin
                    // A dangling escape before the end byte yields nothing.
                    n_mode           = MODE_IDLE;
                    n_raw            = '0;
                    n_dec            = '0;
                    emit             = 1'b1;
                    res.kind         = KIND_COMPLETE;
                    res.frame_length = r_dec;
                end else if (r_mode == MODE_FRAME) begin
                    n_raw = r_raw + RawCountWidth'(1);
                    if (i_byte == EscByte) begin
                        n_mode = MODE_ESCAPE;
                    end else begin
                        n_dec         = r_dec + LenWidth'(1);
                        emit          = 1'b1;
                        res.data_byte = i_byte;
                    end
                end else begin
                    n_raw  = r_raw + RawCountWidth'(1);
                    n_mode = MODE_FRAME;
                    n_dec  = r_dec + LenWidth'(1);
                    emit   = 1'b1;
                    if (i_byte == StartCode) begin
                        res.data_byte = StartByte;
                    end else if (i_byte == EndCode) begin
                        res.data_byte = EndByte;
                    end else if (i_byte == EscCode) begin
                        res.data_byte = EscByte;
                    end else begin
                        res.bad_escape = 1'b1;
                    end
                end
            end
            default: begin
                // Outside a frame only a start byte matters.
                if (i_byte == StartByte) begin
                    n_mode = MODE_FRAME;
                    n_raw  = RawCountWidth'(1);
                end else begin
                    n_mode = MODE_IDLE;
                    n_raw  = '0;
                end
                n_dec = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_raw  <= '0;
            r_dec  <= '0;
        end else if (advance) begin
            r_mode <= n_mode;
            r_raw  <= n_raw;
            r_dec  <= n_dec;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/efr_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efr_out_stage: result register
// Holds one result beat until the sink takes it; refills in the same cycle.
// ----------------------------------------------------------------------------
module efr_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_up_valid,
    input  wire efr_pkg::t_result i_up_res,
    output logic                  o_up_ready,
    efr_out_if.source             o_res
);
    import efr_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;
    logic    load;

    assign o_up_ready = !r_valid || o_res.ready;
    assign load       = i_up_valid && o_up_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (o_res.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (load) begin
            r_res <= i_up_res;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.kind         = r_res.kind;
    assign o_res.data_byte    = r_res.data_byte;
    assign o_res.bad_escape   = r_res.bad_escape;
    assign o_res.frame_length = r_res.frame_length;

endmodule
`default_nettype wire

### hw/rtl/escaped_frame_receiver_top.sv
`default_nettype none
// A raw byte is held in the byte register, decoded, and registered as a result beat.
// Throughput: one raw byte per cycle; the byte register and the result register
// each refill in the cycle they empty, so a stalled sink only stops intake when both are full.
// Bytes that produce no result still pass through the decoder.
// Reset (synchronous, active low) empties both registers and returns to idle outside a frame.
// ----------------------------------------------------------------------------
// escaped_frame_receiver_top: byte-stuffing deframer
// Input register, frame decoder and result register in one pass per byte.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    efr_in_if.sink    i_rx,
    efr_out_if.source o_res
);
    import efr_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       dec_ready;
    logic       res_valid;
    t_result    res;
    logic       res_ready;

    efr_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (i_rx),
        .i_dn_ready (dec_ready),
        .o_dn_valid (in_valid),
        .o_dn_byte  (in_byte)
    );

    efr_decode u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_byte      (in_byte),
        .i_res_ready (res_ready),
        .o_ready     (dec_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    efr_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (res_valid),
        .i_up_res   (res),
        .o_up_ready (res_ready),
        .o_res      (o_res)
    );

endmodule
`default_nettype wire

### hw/rtl/efr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// efr_checker: port-level checks of the escaped frame receiver
// Watches the result channel for stalls and for field combinations.
// ----------------------------------------------------------------------------
module efr_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [1:0]                    i_kind,
    input wire logic [7:0]                    i_data_byte,
    input wire logic                          i_bad_escape,
    input wire logic [efr_pkg::LenWidth-1:0]  i_frame_length
);
    import efr_pkg::*;

    // A stalled result beat keeps its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
        && $stable(i_data_byte) && $stable(i_bad_escape) && $stable(i_frame_length))
        else $error("result beat changed while stalled");

    a_ctrl_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != 2'(KIND_PAYLOAD) |-> i_data_byte == 8'd0 && !i_bad_escape)
        else $error("frame event carries payload data");

    a_length_only_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != 2'(KIND_COMPLETE) |-> i_frame_length == '0)
        else $error("frame length outside a complete event");

    // An unknown escape code always decodes to a zero payload byte.
    a_bad_escape_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad_escape |-> i_kind == 2'(KIND_PAYLOAD) && i_data_byte == 8'd0)
        else $error("bad escape with nonzero data");

endmodule

bind escaped_frame_receiver_top efr_checker u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_kind         (o_res.kind),
    .i_data_byte    (o_res.data_byte),
    .i_bad_escape   (o_res.bad_escape),
    .i_frame_length (o_res.frame_length)
);
`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for escaped_frame_receiver_top
// Drives raw serial bytes with random idle gaps and checks every result beat
// against a cycle-free prediction of the deframer, with random sink stalls.
// ----------------------------------------------------------------------------
module testbench;
    import efr_pkg::*;

    localparam int unsigned CycleLimit   = 200000;
    localparam int          SettleCycles = 10;
    localparam int          RandomItems  = 300;

    typedef enum logic [1:0] {
        FS_IDLE    = 2'd0,
        FS_BODY    = 2'd1,
        FS_ESCAPED = 2'd2
    } t_frame_state;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    efr_in_if  rx_if ();
    efr_out_if res_if ();

    escaped_frame_receiver_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    always #10 i_clk = ~i_clk;

    // Predicted deframer state.
    t_frame_state rx_state     = FS_IDLE;
    logic [7:0]   raw_seen     = '0;
    logic [6:0]   payload_seen = '0;

    t_result     expected_results[$];
    int          mismatches   = 0;
    int          sent_items   = 0;
    int unsigned cycle_count  = 0;
    bit          steady       = 1'b0;

    // Advance the predicted state by one raw byte; returns 1 when a result is due.
    function automatic logic predict_byte(input logic [7:0] b, output t_result r);
        r = '0;
        if (rx_state != FS_BODY && rx_state != FS_ESCAPED) begin
            rx_state     = (b == StartByte) ? FS_BODY : FS_IDLE;
            raw_seen     = (b == StartByte) ? 8'd1 : 8'd0;
            payload_seen = '0;
            return 1'b0;
        end
        if (b == StartByte) begin
            rx_state     = FS_BODY;
            raw_seen     = 8'd1;
            payload_seen = '0;
            r.kind       = KIND_RESTART;
            return 1'b1;
        end
        if (raw_seen >= RawBufferBytes) begin
            rx_state     = FS_IDLE;
            raw_seen     = '0;
            payload_seen = '0;
            r.kind       = KIND_OVERFLOW;
            return 1'b1;
        end
        raw_seen = raw_seen + 8'd1;
        if (b == EndByte) begin
            // A dangling escape before the end byte adds nothing to the length.
            r.kind         = KIND_COMPLETE;
            r.frame_length = payload_seen;
            rx_state       = FS_IDLE;
            raw_seen       = '0;
            payload_seen   = '0;
            return 1'b1;
        end
        if (rx_state == FS_BODY) begin
            if (b == EscByte) begin
                rx_state = FS_ESCAPED;
                return 1'b0;
            end
            payload_seen = payload_seen + 7'd1;
            r.data_byte  = b;
            return 1'b1;
        end
        rx_state     = FS_BODY;
        payload_seen = payload_seen + 7'd1;
        case (b)
            StartCode: r.data_byte = StartByte;
            EndCode:   r.data_byte = EndByte;
            EscCode:   r.data_byte = EscByte;
            default:   r.bad_escape = 1'b1;
        endcase
        return 1'b1;
    endfunction

    // A payload byte that needs no escaping.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == StartByte || b == EndByte || b == EscByte);
        return b;
    endfunction

    // Append n decoded payload bytes, escaping the framing codes; about esc_pct percent
    // of them become escapes with a random (often unknown) code.
    function automatic void add_payload(ref logic [7:0] seq[$], input int n,
                                        input int esc_pct);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom_range(255));
            if ($urandom_range(99) < esc_pct) begin
                do
                    b = 8'($urandom_range(255));
                while (b == StartByte || b == EndByte);
                seq.push_back(EscByte);
                seq.push_back(b);
            end else if (b == StartByte) begin
                seq.push_back(EscByte);
                seq.push_back(StartCode);
            end else if (b == EndByte) begin
                seq.push_back(EscByte);
                seq.push_back(EndCode);
            end else if (b == EscByte) begin
                seq.push_back(EscByte);
                seq.push_back(EscCode);
            end else begin
                seq.push_back(b);
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        t_result exp;
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge i_clk);
        while (!rx_if.ready);
        sent_items++;
        if (predict_byte(b, exp))
            expected_results.push_back(exp);
        if (!steady && $urandom_range(99) < 20) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_seq(input logic [7:0] seq[$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Hold the input channel idle until every predicted beat has come out.
    task automatic wait_all_done();
        rx_if.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (expected_results.size() != 0);
    endtask

    task automatic report_mismatch(input bit unexpected, input t_result exp,
                                   input t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            if (unexpected) begin
                $display("unexpected result beat: kind=%0d data=%02h bad=%0b len=%0d",
                         got.kind, got.data_byte, got.bad_escape, got.frame_length);
            end else begin
                $display("mismatch: expected kind=%0d data=%02h bad=%0b len=%0d",
                         exp.kind, exp.data_byte, exp.bad_escape, exp.frame_length);
                $display("          got      kind=%0d data=%02h bad=%0b len=%0d",
                         got.kind, got.data_byte, got.bad_escape, got.frame_length);
            end
        end
    endtask

    always @(posedge i_clk) begin
        res_if.ready <= steady || ($urandom_range(99) >= 20);
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result exp;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.kind         = res_if.kind;
            got.data_byte    = res_if.data_byte;
            got.bad_escape   = res_if.bad_escape;
            got.frame_length = res_if.frame_length;
            if (expected_results.size() == 0) begin
                report_mismatch(1'b1, got, got);
            end else begin
                exp = expected_results.pop_front();
                if (got.kind !== exp.kind || got.data_byte !== exp.data_byte ||
                    got.bad_escape !== exp.bad_escape ||
                    got.frame_length !== exp.frame_length)
                    report_mismatch(1'b0, exp, got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("[escaped_frame_receiver_top] ERROR");
            $finish;
        end
    end

    task automatic test_ignored_bytes();
        logic [7:0] seq[$];
        seq = '{8'h00, 8'hFF, EscByte};
        send_seq(seq);
    endtask

    task automatic test_plain_frame();
        logic [7:0] seq[$];
        seq = '{StartByte, 8'h00, 8'hFF, EndByte};
        send_seq(seq);
    endtask

    task automatic test_escape_codes();
        logic [7:0] seq[$];
        seq = '{StartByte, EscByte, StartCode, EscByte, EndCode, EscByte, EscCode,
                EscByte, 8'hFF, EndByte};
        send_seq(seq);
    endtask

    // Restart inside a frame, restart right after an escape, and an end byte
    // that follows an escape.
    task automatic test_restart_and_dangling_escape();
        logic [7:0] seq[$];
        seq = '{StartByte, 8'h41, StartByte, EscByte, StartByte, EscByte, EndByte};
        send_seq(seq);
    endtask

    // Frames right at the raw buffer size and one byte past it; past it the extra byte is an end, start or escape byte.
    task automatic test_buffer_limits();
        logic [7:0] seq[$];
        for (int variant = 0; variant < 4; variant++) begin
            seq.delete();
            seq.push_back(StartByte);
            repeat (variant == 0 ? RawBufferBytes - 2 : RawBufferBytes - 1)
                seq.push_back(plain_byte());
            case (variant)
                0, 1: seq.push_back(EndByte);
                2:    seq.push_back(StartByte);
                default: begin
                    seq.push_back(EscByte);
                    seq.push_back(EndByte);
                end
            endcase
            send_seq(seq);
        end
    endtask

    task automatic test_random_traffic();
        logic [7:0] seq[$];
        int         pick;
        bit         drained;
        drained    = 1'b0;
        sent_items = 0;
        while (sent_items < RandomItems) begin
            steady = (sent_items >= 100 && sent_items < 200);
            if (!drained && sent_items >= 220) begin
                wait_all_done();
                drained = 1'b1;
            end
            pick = $urandom_range(99);
            seq.delete();
            if (pick < 65) begin
                seq.push_back(StartByte);
                add_payload(seq, $urandom_range(0, 12), 15);
                seq.push_back(EndByte);
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 4))
                    seq.push_back(8'($urandom_range(255)));
            end else if (pick < 85) begin
                seq.push_back(StartByte);
                add_payload(seq, $urandom_range(0, 6), 15);
                if ($urandom_range(1))
                    seq.push_back(EscByte);
                seq.push_back(StartByte);
            end else if (pick < 92) begin
                seq.push_back(StartByte);
                add_payload(seq, $urandom_range(0, 6), 15);
                seq.push_back(EscByte);
                seq.push_back(EndByte);
            end else if (pick < 98) begin
                // Unescaped raw bytes: the frame may end, restart or run on.
                seq.push_back(StartByte);
                repeat ($urandom_range(1, 10))
                    seq.push_back(8'($urandom_range(255)));
            end else begin
                seq.push_back(StartByte);
                add_payload(seq, $urandom_range(100, 130), 10);
                seq.push_back(EndByte);
            end
            send_seq(seq);
        end
        steady = 1'b0;
    endtask

    initial begin
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_ignored_bytes();
        test_plain_frame();
        test_escape_codes();
        test_restart_and_dangling_escape();
        wait_all_done();
        test_buffer_limits();
        test_random_traffic();

        wait_all_done();
        repeat (SettleCycles) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[escaped_frame_receiver_top] OK");
        end else begin
            $display("[escaped_frame_receiver_top] ERROR");
        end
        $finish;
    end
endmodule
